/* src/cop_pkg.sv */
// shared types and constants for the circle overlap push-out block
package cop_pkg;

    localparam int COORD_BITS = 24;
    localparam int RAD_BITS   = COORD_BITS - 2;
    localparam int ROOT_BITS  = COORD_BITS - 1;
    localparam int SQ_BITS    = 2 * COORD_BITS + 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_center_x;
        logic signed [COORD_BITS-1:0] a_center_y;
        logic        [RAD_BITS-1:0]   a_radius;
        logic signed [COORD_BITS-1:0] b_center_x;
        logic signed [COORD_BITS-1:0] b_center_y;
        logic        [RAD_BITS-1:0]   b_radius;
    } t_in;

    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] push_x;
        logic signed [COORD_BITS-1:0] push_y;
    } t_out;

    typedef struct packed {
        logic                 hit;
        logic                 zero;
        logic                 neg_x;
        logic                 neg_y;
        logic [ROOT_BITS-1:0] mag_x;
        logic [ROOT_BITS-1:0] mag_y;
        logic [ROOT_BITS-1:0] rsum;
    } t_tag;

    localparam int TAG_BITS = $bits(t_tag);

endpackage

/* src/cop_sqrt.sv */
// pipelined integer square root, one result bit per stage
module cop_sqrt #(
    parameter int RW = 23,
    parameter int TW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_rad,
    input  logic [TW-1:0]   i_tag,
    output logic            o_ready,
    input  logic            i_ready,
    output logic            o_valid,
    output logic [RW-1:0]   o_root,
    output logic [TW-1:0]   o_tag
);

    logic            r_v    [RW];
    logic [RW+1:0]   r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [2*RW-1:0] r_rad  [RW];
    logic [TW-1:0]   r_tag  [RW];
    logic [RW:0]     w_rdy;

    assign w_rdy[RW] = i_ready;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic            s_v;
        logic [RW+1:0]   s_rem;
        logic [RW-1:0]   s_root;
        logic [2*RW-1:0] s_rad;
        logic [TW-1:0]   s_tag;
        logic [RW+1:0]   s_acc;
        logic [RW+1:0]   s_trial;
        logic [RW+1:0]   n_rem;
        logic [RW-1:0]   n_root;

        if (k == 0) begin : g_first
            assign s_v    = i_valid;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_rad  = i_rad;
            assign s_tag  = i_tag;
        end else begin : g_next
            assign s_v    = r_v[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
            assign s_rad  = r_rad[k-1];
            assign s_tag  = r_tag[k-1];
        end

        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

        // bring down two radicand bits, try root*4+1
        always_comb begin
            s_acc   = {s_rem[RW-1:0], s_rad[2*RW-1 -: 2]};
            s_trial = {s_root, 2'b01};
            if (s_acc >= s_trial) begin
                n_rem  = s_acc - s_trial;
                n_root = {s_root[RW-2:0], 1'b1};
            end else begin
                n_rem  = s_acc;
                n_root = {s_root[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_rad[k]  <= {s_rad[2*RW-3:0], 2'b00};
                r_tag[k]  <= s_tag;
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_tag   = r_tag[RW-1];

endmodule

/* src/cop_div.sv */
// pipelined two-lane restoring divider with a shared divisor
module cop_div #(
    parameter int QW = 23,
    parameter int DW = 23,
    parameter int TW = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [QW+DW-1:0] i_num_x,
    input  logic [QW+DW-1:0] i_num_y,
    input  logic [DW-1:0]    i_den,
    input  logic [TW-1:0]    i_tag,
    output logic             o_ready,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [QW-1:0]    o_quo_x,
    output logic [QW-1:0]    o_quo_y,
    output logic [TW-1:0]    o_tag
);

    localparam int NW = QW + DW;

    logic          r_v     [QW];
    logic [NW-1:0] r_rem_x [QW];
    logic [NW-1:0] r_rem_y [QW];
    logic [QW-1:0] r_q_x   [QW];
    logic [QW-1:0] r_q_y   [QW];
    logic [DW-1:0] r_den   [QW];
    logic [TW-1:0] r_tag   [QW];
    logic [QW:0]   w_rdy;

    assign w_rdy[QW] = i_ready;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          s_v;
        logic [NW-1:0] s_rem_x;
        logic [NW-1:0] s_rem_y;
        logic [QW-1:0] s_q_x;
        logic [QW-1:0] s_q_y;
        logic [DW-1:0] s_den;
        logic [TW-1:0] s_tag;
        logic [NW-1:0] s_sh;
        logic          s_ge_x;
        logic          s_ge_y;

        if (k == 0) begin : g_first
            assign s_v     = i_valid;
            assign s_rem_x = i_num_x;
            assign s_rem_y = i_num_y;
            assign s_q_x   = '0;
            assign s_q_y   = '0;
            assign s_den   = i_den;
            assign s_tag   = i_tag;
        end else begin : g_next
            assign s_v     = r_v[k-1];
            assign s_rem_x = r_rem_x[k-1];
            assign s_rem_y = r_rem_y[k-1];
            assign s_q_x   = r_q_x[k-1];
            assign s_q_y   = r_q_y[k-1];
            assign s_den   = r_den[k-1];
            assign s_tag   = r_tag[k-1];
        end

        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

        // divisor aligned to this quotient bit
        assign s_sh   = {{QW{1'b0}}, s_den} << (QW - 1 - k);
        assign s_ge_x = s_rem_x >= s_sh;
        assign s_ge_y = s_rem_y >= s_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_rem_x[k] <= s_ge_x ? s_rem_x - s_sh : s_rem_x;
                r_rem_y[k] <= s_ge_y ? s_rem_y - s_sh : s_rem_y;
                r_q_x[k]   <= {s_q_x[QW-2:0], s_ge_x};
                r_q_y[k]   <= {s_q_y[QW-2:0], s_ge_y};
                r_den[k]   <= s_den;
                r_tag[k]   <= s_tag;
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[QW-1];
    assign o_quo_x = r_q_x[QW-1];
    assign o_quo_y = r_q_y[QW-1];
    assign o_tag   = r_tag[QW-1];

endmodule

/* src/circle_overlap_push_out.sv */
// circle-circle collision test with push-out vector, top level
//
// input channel: i_in_valid / o_in_stall carry one t_in transaction, two
// circles with signed q11.12 centres and unsigned q10.12 radii
// output channel: o_out_valid / i_out_stall carry one t_out transaction per
// input: hit flag and the push-out vector in q11.12
// a transaction moves at a rising edge with valid high and stall low
// path from input transaction to output valid: 3 front stages, 23 square-root
// stages, 2 scaling stages, 23 divider stages, output register
// throughput: one transaction per cycle while the output is not stalled, set by
// the fully pipelined square-root and divider stages
// each stage holds its data when the stage after it is full and stalled,
// so bubbles collapse and the input keeps flowing while results wait, until every stage is full
// reset clears every stage valid bit; payload registers are not reset
// no hit gives zero push; coincident centres give push (radius sum, 0)
module circle_overlap_push_out
    import cop_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int C = COORD_BITS;
    localparam int R = ROOT_BITS;

    // stage 1: centre differences and radius sum
    logic                r_v1;
    logic signed [C:0]   r_dx;
    logic signed [C:0]   r_dy;
    logic [R-1:0]        r_rsum1;
    // stage 2: squares
    logic                r_v2;
    logic [SQ_BITS-1:0]  r_sqx;
    logic [SQ_BITS-1:0]  r_sqy;
    logic [2*R-1:0]      r_rsq;
    logic                r_neg_x2;
    logic                r_neg_y2;
    logic [R-1:0]        r_mx2;
    logic [R-1:0]        r_my2;
    logic [R-1:0]        r_rsum2;
    // stage 3: hit decision, radicand
    logic                r_v3;
    logic [2*R-1:0]      r_rad;
    t_tag                r_tag3;
    // stage 4: overlap times magnitude
    logic                r_v4;
    logic [2*R-1:0]      r_px;
    logic [2*R-1:0]      r_py;
    logic [R-1:0]        r_dist4;
    t_tag                r_tag4;
    // stage 5: rounding bias added
    logic                r_v5;
    logic [2*R-1:0]      r_num_x;
    logic [2*R-1:0]      r_num_y;
    logic [R-1:0]        r_dist5;
    t_tag                r_tag5;
    // output register
    logic                r_ov;
    t_out                r_out;

    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;
    logic sq_ready, sq_valid, dv_ready, dv_valid;
    logic [R-1:0]        sq_root;
    logic [TAG_BITS-1:0] sq_tag_bits;
    t_tag                sq_tag;
    logic [R-1:0]        dv_qx;
    logic [R-1:0]        dv_qy;
    logic [TAG_BITS-1:0] dv_tag_bits;
    t_tag                dv_tag;

    // stall chain: a stage may load when empty or when its successor loads
    assign rdy_out    = !r_ov || !i_out_stall;
    assign rdy5       = !r_v5 || dv_ready;
    assign rdy4       = !r_v4 || rdy5;
    assign rdy3       = !r_v3 || sq_ready;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_in_stall = !rdy1;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (rdy1)    r_v1 <= i_in_valid;
            if (rdy2)    r_v2 <= r_v1;
            if (rdy3)    r_v3 <= r_v2;
            if (rdy4)    r_v4 <= sq_valid;
            if (rdy5)    r_v5 <= r_v4;
            if (rdy_out) r_ov <= dv_valid;
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_dx    <= $signed({i_in_data.b_center_x[C-1], i_in_data.b_center_x})
                     - $signed({i_in_data.a_center_x[C-1], i_in_data.a_center_x});
            r_dy    <= $signed({i_in_data.b_center_y[C-1], i_in_data.b_center_y})
                     - $signed({i_in_data.a_center_y[C-1], i_in_data.a_center_y});
            r_rsum1 <= {1'b0, i_in_data.a_radius} + {1'b0, i_in_data.b_radius};
        end
    end

    // stage 2: magnitudes and squares
    logic [C:0] s_mx;
    logic [C:0] s_my;
    assign s_mx = r_dx[C] ? (~r_dx + 1'b1) : r_dx;
    assign s_my = r_dy[C] ? (~r_dy + 1'b1) : r_dy;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_sqx    <= SQ_BITS'(s_mx * s_mx);
            r_sqy    <= SQ_BITS'(s_my * s_my);
            r_rsq    <= r_rsum1 * r_rsum1;
            r_neg_x2 <= r_dx[C];
            r_neg_y2 <= r_dy[C];
            // on a hit each magnitude is at most the distance, so R bits do
            r_mx2    <= s_mx[R-1:0];
            r_my2    <= s_my[R-1:0];
            r_rsum2  <= r_rsum1;
        end
    end

    // stage 3: squared distance against squared radius sum
    logic [SQ_BITS-1:0] s_sqd;
    assign s_sqd = r_sqx + r_sqy;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_rad        <= s_sqd[2*R-1:0];
            r_tag3.hit   <= s_sqd <= SQ_BITS'(r_rsq);
            r_tag3.zero  <= s_sqd == '0;
            r_tag3.neg_x <= r_neg_x2;
            r_tag3.neg_y <= r_neg_y2;
            r_tag3.mag_x <= r_mx2;
            r_tag3.mag_y <= r_my2;
            r_tag3.rsum  <= r_rsum2;
        end
    end

    cop_sqrt #(
        .RW (R),
        .TW (TAG_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_rad   (r_rad),
        .i_tag   (r_tag3),
        .o_ready (sq_ready),
        .i_ready (rdy4),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_tag   (sq_tag_bits)
    );

    assign sq_tag = t_tag'(sq_tag_bits);

    // stage 4: overlap, never negative on a hit
    logic [R-1:0] s_overlap;
    assign s_overlap = sq_tag.rsum - sq_root;

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_px    <= sq_tag.mag_x * s_overlap;
            r_py    <= sq_tag.mag_y * s_overlap;
            r_dist4 <= sq_root;
            r_tag4  <= sq_tag;
        end
    end

    // stage 5: half the divisor for round to nearest, ties away from zero
    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_num_x <= r_px + (2*R)'(r_dist4 >> 1);
            r_num_y <= r_py + (2*R)'(r_dist4 >> 1);
            r_dist5 <= r_dist4;
            r_tag5  <= r_tag4;
        end
    end

    cop_div #(
        .QW (R),
        .DW (R),
        .TW (TAG_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v5),
        .i_num_x (r_num_x),
        .i_num_y (r_num_y),
        .i_den   (r_dist5),
        .i_tag   (r_tag5),
        .o_ready (dv_ready),
        .i_ready (rdy_out),
        .o_valid (dv_valid),
        .o_quo_x (dv_qx),
        .o_quo_y (dv_qy),
        .o_tag   (dv_tag_bits)
    );

    assign dv_tag = t_tag'(dv_tag_bits);

    // output: quotients stay below the radius sum, so no saturation is reached
    t_out n_out;
    always_comb begin
        n_out.hit    = dv_tag.hit;
        n_out.push_x = '0;
        n_out.push_y = '0;
        if (dv_tag.hit) begin
            if (dv_tag.zero) begin
                n_out.push_x = C'(dv_tag.rsum);
            end else begin
                n_out.push_x = dv_tag.neg_x ? -$signed(C'(dv_qx)) : $signed(C'(dv_qx));
                n_out.push_y = dv_tag.neg_y ? -$signed(C'(dv_qy)) : $signed(C'(dv_qy));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

/* src/cop_checker.sv */
// port-level checker for the circle overlap push-out block, with its bind
module cop_checker
    import cop_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    localparam logic signed [COORD_BITS-1:0] MOST_NEG = {1'b1, {(COORD_BITS-1){1'b0}}};

    // a stalled result transaction stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result valid dropped while stalled");

    // no hit means no push
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.hit |-> o_out_data.push_x == '0 && o_out_data.push_y == '0)
        else $error("push without hit");

    // the push is never the most negative code
    a_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.push_x != MOST_NEG && o_out_data.push_y != MOST_NEG)
        else $error("push reached the most negative code");

    // a y push only comes with a hit
    a_push_y_only_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.push_y != '0 |-> o_out_data.hit)
        else $error("y push without hit");

endmodule

bind circle_overlap_push_out cop_checker u_cop_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
